>>> rtl/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter core.
// No dependencies; every other file of the block refers to this package.
package skf_pkg;

	// Fixed field widths
	localparam int COV_W = 24;   // covariance and noise registers, unsigned Q8.F
	localparam int EST_W = 32;   // estimate, signed Q16.F
	localparam int APB_AW = 4;   // three registers at byte addresses 0, 4, 8
	localparam int APB_DW = 32;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
	localparam logic [1:0] REG_MEASURE_NOISE = 2'd1;
	localparam logic [1:0] REG_INIT_COV      = 2'd2;

	// Register reset values
	localparam logic [COV_W-1:0] PROCESS_NOISE_RST = 24'd66;
	localparam logic [COV_W-1:0] MEASURE_NOISE_RST = 24'd3277;
	localparam logic [COV_W-1:0] INIT_COV_RST      = 24'd3276800;
	localparam logic [COV_W-1:0] COV_MAX           = '1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_START,
		ST_DIV,
		ST_MUL_EST,
		ST_MUL_COV,
		ST_UPDATE
	} state_t;

endpackage

>>> rtl/skf_div.sv
// Iterative restoring divider for the gain pp * 2^F / (pp + r).
// One quotient bit per cycle, FRAC_BITS+1 bits in all. Uses skf_pkg.
module skf_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [skf_pkg::COV_W-1:0] pp,
	input  logic [skf_pkg::COV_W-1:0] rn,
	output logic                      done,
	output logic [FRAC_BITS:0]        gain
);

	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam int DW = skf_pkg::COV_W + 1;   // denominator
	localparam int RW = skf_pkg::COV_W + 2;   // partial remainder, below 2*den
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [DW-1:0]      den_q;
	logic [RW-1:0]      rem_q;
	logic [FRAC_BITS:0] quot_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               ge;
	logic [RW-1:0]      rem_nxt;

	// Trial subtract; quotient never exceeds one since pp <= den
	assign ge      = rem_q >= RW'(den_q);
	assign rem_nxt = ge ? (rem_q - RW'(den_q)) : rem_q;

	// Control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(FRAC_BITS);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= DW'(pp) + DW'(rn);
			rem_q  <= RW'(pp);
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= {rem_nxt[RW-2:0], 1'b0};
			quot_q <= {quot_q[FRAC_BITS-1:0], ge};
		end
	end

	// Zero denominator: gain of one
	assign gain = (den_q == '0) ? ONE : quot_q;
	assign done = done_q;

endmodule

>>> rtl/scalar_kalman_filter_core.sv
// Top level of the scalar Kalman filter: APB registers, sequencer, shared multiplier.
// Depends on skf_pkg and skf_div.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  sample    | sample_valid, sample_ready, sample        | in
//  result    | result_valid, result_ready, estimate, gain| out
//  apb       | psel, penable, pwrite, paddr, pwdata,     | in/out
//            | prdata, pready                            |
//
// A word's result is valid once the sequencer has stepped through prepare, divider start,
// the bit-serial gain divide, two passes through the one multiplier and the update;
// the next word can be taken only after that.
// sample_ready is high only in idle; one word is processed at a time.
// A finished result waits in the output register; the next word is accepted meanwhile
// and stalls in its final step only if the earlier result is still not taken.
// Reset loads the register defaults, a zero estimate and the initial covariance.
module scalar_kalman_filter_core #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [skf_pkg::APB_AW-1:0]         paddr,
	input  logic [skf_pkg::APB_DW-1:0]         pwdata,
	output logic [skf_pkg::APB_DW-1:0]         prdata,
	output logic                               pready,
	// sample input
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	// result output
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [skf_pkg::EST_W-1:0]   estimate,
	output logic [FRAC_BITS:0]                 gain
);

	localparam int CV = skf_pkg::COV_W;
	localparam int EW = skf_pkg::EST_W;
	localparam int TW = (SAMPLE_BITS + FRAC_BITS > EW + 1) ? SAMPLE_BITS + FRAC_BITS : EW + 1;
	localparam int MB = (FRAC_BITS + 1 > CV) ? FRAC_BITS + 1 : CV;   // multiplier B width
	localparam int PW = EW + MB;                                      // product width
	localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PW:0]        HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

	// Registers and state
	skf_pkg::state_t        state_q, state_d;
	logic [CV-1:0]          process_noise_q;
	logic [CV-1:0]          measure_noise_q;
	logic [CV-1:0]          init_cov_q;
	logic [CV-1:0]          cov_q;
	logic signed [EW-1:0]   est_q;
	logic [EW-1:0]          target_q;
	logic [CV-1:0]          pp_q;
	logic [EW-1:0]          mag_q;
	logic                   neg_q;
	logic [FRAC_BITS:0]     gain_q;
	logic [FRAC_BITS:0]     gain_out_q;
	logic [PW-1:0]          prod_q;
	logic [EW:0]            qv_q;
	logic                   result_valid_q;

	logic                   cfg_wr;
	logic                   accept;
	logic                   upd_fire;
	logic                   div_start;
	logic                   div_done;
	logic [FRAC_BITS:0]     div_gain;
	logic signed [TW-1:0]   scaled;
	logic [EW-1:0]          target_d;
	logic [CV:0]            pp_sum;
	logic [CV-1:0]          pp_d;
	logic signed [EW:0]     diff;
	logic [EW:0]            diff_abs;
	logic [EW-1:0]          mul_a;
	logic [MB-1:0]          mul_b;
	logic [PW-1:0]          mul_p;
	logic [PW:0]            rnd;
	logic [PW:0]            rnd_sh;
	logic signed [EW+1:0]   delta;
	logic signed [EW+1:0]   est_sum;
	logic [EW-1:0]          est_d;

	// APB write strobe and read mux
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			skf_pkg::REG_PROCESS_NOISE: prdata = skf_pkg::APB_DW'(process_noise_q);
			skf_pkg::REG_MEASURE_NOISE: prdata = skf_pkg::APB_DW'(measure_noise_q);
			skf_pkg::REG_INIT_COV:      prdata = skf_pkg::APB_DW'(init_cov_q);
			default:                    prdata = '0;
		endcase
	end

	// Handshake
	assign sample_ready = (state_q == skf_pkg::ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign upd_fire     = (state_q == skf_pkg::ST_UPDATE) && (!result_valid_q || result_ready);
	assign div_start    = (state_q == skf_pkg::ST_START);

	// Sample scaled to Q.F and clamped to the 32-bit range
	assign scaled = TW'(sample) <<< FRAC_BITS;
	always_comb begin
		if ((&scaled[TW-1:EW-1]) || !(|scaled[TW-1:EW-1])) begin
			target_d = scaled[EW-1:0];
		end else if (scaled[TW-1]) begin
			target_d = {1'b1, {(EW-1){1'b0}}};
		end else begin
			target_d = {1'b0, {(EW-1){1'b1}}};
		end
	end

	// Predicted covariance, saturating
	assign pp_sum = (CV + 1)'(cov_q) + (CV + 1)'(process_noise_q);
	assign pp_d   = pp_sum[CV] ? skf_pkg::COV_MAX : pp_sum[CV-1:0];

	// Innovation magnitude and sign
	assign diff     = $signed({target_q[EW-1], target_q}) - $signed({est_q[EW-1], est_q});
	assign diff_abs = diff[EW] ? (EW + 1)'(-diff) : (EW + 1)'(diff);

	// Shared multiplier: gain * |diff|, then (1 - gain) * pp
	always_comb begin
		if (state_q == skf_pkg::ST_MUL_EST) begin
			mul_a = mag_q;
			mul_b = MB'(gain_q);
		end else begin
			mul_a = EW'(pp_q);
			mul_b = MB'(ONE - gain_q);
		end
	end
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// Round to nearest and drop the fraction
	assign rnd    = (PW + 1)'(prod_q) + HALF;
	assign rnd_sh = rnd >> FRAC_BITS;

	// Estimate update with saturation
	assign delta   = neg_q ? -$signed((EW + 2)'(qv_q)) : $signed((EW + 2)'(qv_q));
	assign est_sum = $signed({{2{est_q[EW-1]}}, est_q}) + delta;
	always_comb begin
		if ((&est_sum[EW+1:EW-1]) || !(|est_sum[EW+1:EW-1])) begin
			est_d = est_sum[EW-1:0];
		end else if (est_sum[EW+1]) begin
			est_d = {1'b1, {(EW-1){1'b0}}};
		end else begin
			est_d = {1'b0, {(EW-1){1'b1}}};
		end
	end

	// Gain divider
	skf_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.pp    (pp_q),
		.rn    (measure_noise_q),
		.done  (div_done),
		.gain  (div_gain)
	);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skf_pkg::ST_IDLE:    if (accept) state_d = skf_pkg::ST_PREP;
			skf_pkg::ST_PREP:    state_d = skf_pkg::ST_START;
			skf_pkg::ST_START:   state_d = skf_pkg::ST_DIV;
			skf_pkg::ST_DIV:     if (div_done) state_d = skf_pkg::ST_MUL_EST;
			skf_pkg::ST_MUL_EST: state_d = skf_pkg::ST_MUL_COV;
			skf_pkg::ST_MUL_COV: state_d = skf_pkg::ST_UPDATE;
			skf_pkg::ST_UPDATE:  if (upd_fire) state_d = skf_pkg::ST_IDLE;
			default:             state_d = skf_pkg::ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q <= skf_pkg::PROCESS_NOISE_RST;
			measure_noise_q <= skf_pkg::MEASURE_NOISE_RST;
			init_cov_q      <= skf_pkg::INIT_COV_RST;
			cov_q           <= skf_pkg::INIT_COV_RST;
			est_q           <= '0;
			result_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					skf_pkg::REG_PROCESS_NOISE: process_noise_q <= pwdata[CV-1:0];
					skf_pkg::REG_MEASURE_NOISE: measure_noise_q <= pwdata[CV-1:0];
					skf_pkg::REG_INIT_COV: begin
						init_cov_q <= pwdata[CV-1:0];
						cov_q      <= pwdata[CV-1:0];
					end
					default: ;
				endcase
			end
			if (upd_fire) begin
				est_q          <= est_d;
				cov_q          <= rnd_sh[CV-1:0];
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= target_d;
		end
		if (state_q == skf_pkg::ST_PREP) begin
			pp_q  <= pp_d;
			mag_q <= diff_abs[EW-1:0];
			neg_q <= diff[EW];
		end
		if (div_done) begin
			gain_q <= div_gain;
		end
		if (state_q == skf_pkg::ST_MUL_EST || state_q == skf_pkg::ST_MUL_COV) begin
			prod_q <= mul_p;
		end
		if (state_q == skf_pkg::ST_MUL_COV) begin
			qv_q <= rnd_sh[EW:0];
		end
		if (upd_fire) begin
			gain_out_q <= gain_q;
		end
	end

	assign result_valid = result_valid_q;
	assign estimate     = est_q;
	assign gain         = gain_out_q;

`ifndef ASSERT_OFF
	// Divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == skf_pkg::ST_DIV)
		else $error("divider done outside divide step");

	// Reported gain never exceeds one
	a_gain_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> gain_out_q <= ONE)
		else $error("gain above one");

	// Updated covariance never exceeds the predicted one
	a_cov_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> cov_q <= $past(pp_q))
		else $error("covariance grew in update");

	// A new result is loaded only when the previous one is gone or taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |-> (!result_valid_q || result_ready))
		else $error("pending result overwritten");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for scalar_kalman_filter_core: directed table, then random phases.
// Depends on skf_pkg and the core RTL; predicts each estimate/gain word in fixed point.
module testbench;
	import skf_pkg::*;

	localparam int SAMPLE_W = 16;
	localparam int FRAC = 16;
	localparam longint unsigned ONE = 64'd1 << FRAC;
	localparam longint unsigned HALF = ONE >> 1;
	localparam longint EST_HI = (64'sd1 <<< 31) - 1;
	localparam longint EST_LO = -(64'sd1 <<< 31);
	localparam int LATENCY = FRAC + 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 5;
	localparam int WORDS_PER_PHASE = 90;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_FROM = 250;
	localparam int CALM_TO = 330;
	localparam int DIRECTED_ROWS = 32;
	localparam logic [1:0] REG_NONE = 2'd3;   // index with no register behind it
	localparam logic [FRAC:0] GAIN_ONE = 17'd65536;

	typedef struct packed {
		logic signed [EST_W-1:0] estimate;
		logic [FRAC:0]           gain;
	} filter_out_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

	typedef struct packed {
		row_kind_e               kind;
		logic [1:0]              idx;
		logic [31:0]             value;
		logic signed [SAMPLE_W-1:0] sample;
		logic                    typed;
		logic signed [EST_W-1:0] estimate;
		logic [FRAC:0]           gain;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [EST_W-1:0] estimate;
	logic [FRAC:0] gain;

	// Filter state and register copies kept by the bench
	logic [COV_W-1:0] q_noise = PROCESS_NOISE_RST;
	logic [COV_W-1:0] r_noise = MEASURE_NOISE_RST;
	logic [COV_W-1:0] p_init = INIT_COV_RST;
	logic [COV_W-1:0] p_cov = INIT_COV_RST;
	logic signed [EST_W-1:0] x_est = '0;
	filter_out_t expected_words[$];

	int mismatches = 0;
	int results_seen = 0;
	int samples_sent = 0;

	// Extremes first, then an unmapped write, zero denominator, saturation, zero gain and unit gain
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh0000, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh7FFF, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh8000, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh0001, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'shFFFF, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh2AAA, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'shD555, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_NONE, 32'hFFFF_FFFF, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sd100, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_PROCESS_NOISE, 32'h0, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_MEASURE_NOISE, 32'h0, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_INIT_COV, 32'h0, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh7FFF, 1'b1, 32'sh7FFF_0000, GAIN_ONE},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh8000, 1'b1, 32'sh8000_0000, GAIN_ONE},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh0000, 1'b1, 32'sh0000_0000, GAIN_ONE},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'shFFFF, 1'b1, 32'shFFFF_0000, GAIN_ONE},
		'{ROW_WRITE, REG_PROCESS_NOISE, 32'hFFFF_FFFF, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_MEASURE_NOISE, 32'hFFFF_FFFF, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_INIT_COV, 32'hFFFF_FFFF, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh7FFF, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh8000, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sh5555, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_PROCESS_NOISE, 32'h0, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_MEASURE_NOISE, 32'h00FF_FFFF, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_INIT_COV, 32'h0, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sd1000, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, -16'sd1000, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_MEASURE_NOISE, 32'h0, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_PROCESS_NOISE, 32'h1, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_WRITE, REG_INIT_COV, 32'h1, 16'sh0, 1'b0, 32'sh0, 17'd0},
		'{ROW_SAMPLE, REG_NONE, 32'h0, 16'sd12345, 1'b1, 32'sd809041920, GAIN_ONE},
		'{ROW_SAMPLE, REG_NONE, 32'h0, -16'sd12345, 1'b1, -32'sd809041920, GAIN_ONE}
	};

	scalar_kalman_filter_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.estimate    (estimate),
		.gain        (gain)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp_est(longint v);
		if (v > EST_HI) return EST_HI;
		if (v < EST_LO) return EST_LO;
		return v;
	endfunction

	// One filter step: predict covariance, gain, estimate move, covariance update
	function automatic filter_out_t kalman_update(logic signed [SAMPLE_W-1:0] z);
		longint unsigned pp, den, k, mag, rounded, newp;
		longint target, diff, delta, sum;
		filter_out_t o;
		pp = 64'(p_cov) + 64'(q_noise);
		if (pp > 64'(COV_MAX)) pp = 64'(COV_MAX);
		den = pp + 64'(r_noise);
		if (den == 0) k = ONE;
		else k = (pp << FRAC) / den;
		target = clamp_est(longint'(z) * longint'(ONE));
		diff = target - longint'(x_est);
		if (diff < 0) mag = -diff;
		else mag = diff;
		// round half away from zero on the magnitude
		rounded = (mag * k + HALF) >> FRAC;
		delta = (diff < 0) ? -longint'(rounded) : longint'(rounded);
		sum = clamp_est(longint'(x_est) + delta);
		x_est = sum[EST_W-1:0];
		newp = ((ONE - k) * pp + HALF) >> FRAC;
		if (newp > 64'(COV_MAX)) newp = 64'(COV_MAX);
		p_cov = newp[COV_W-1:0];
		o.estimate = x_est;
		o.gain = k[FRAC:0];
		return o;
	endfunction

	function automatic void apply_register_write(logic [1:0] idx, logic [31:0] value);
		case (idx)
		REG_PROCESS_NOISE: q_noise = value[COV_W-1:0];
		REG_MEASURE_NOISE: r_noise = value[COV_W-1:0];
		REG_INIT_COV: begin
			p_init = value[COV_W-1:0];
			p_cov = value[COV_W-1:0];
		end
		default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string what, logic signed [63:0] want,
		logic signed [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s wrong near word %0d: expected %0d (%h), got %0d (%h)",
				what, results_seen, want, want, got, got);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] random_sample(int level);
		int pick, v;
		pick = $urandom_range(99);
		if (pick < 40) begin
			// noisy reading around a steady level
			v = level + int'($urandom_range(64)) - 32;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[SAMPLE_W-1:0];
		end
		if (pick < 75) return SAMPLE_W'($urandom);
		if (pick < 85) return SAMPLE_W'(int'($urandom_range(400)) - 200);
		case ($urandom_range(3))
		0: return 16'sh8000;
		1: return 16'sh7FFF;
		2: return 16'sh0000;
		default: return 16'shFFFF;
		endcase
	endfunction

	function automatic logic [31:0] random_register_value();
		logic [COV_W-1:0] v;
		case ($urandom_range(4))
		0: v = '0;
		1: v = COV_MAX;
		2: v = COV_W'($urandom_range(16'hFFFF));
		3: v = COV_W'($urandom_range(10'h3FF));
		default: v = COV_W'($urandom);
		endcase
		// upper byte is don't-care on the bus, keep it toggling
		return {8'($urandom), v};
	endfunction

	// Lower valid and wait until every predicted word has come back
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic apb_cycle(input logic [1:0] idx, input logic write_op,
		input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write_op;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Register write while idle, then read back unless the index is unmapped
	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		logic [31:0] readback;
		logic [COV_W-1:0] held;
		drain();
		apb_cycle(idx, 1'b1, value, readback);
		apply_register_write(idx, value);
		if (idx != REG_NONE) begin
			apb_cycle(idx, 1'b0, '0, readback);
			case (idx)
			REG_PROCESS_NOISE: held = q_noise;
			REG_MEASURE_NOISE: held = r_noise;
			default: held = p_init;
			endcase
			if (readback !== 32'(held)) note_mismatch("register readback", held, readback);
		end
	endtask

	// Offer one word, possibly after an idle gap, and predict on acceptance
	task automatic send_sample(logic signed [SAMPLE_W-1:0] z, logic typed,
		filter_out_t typed_out);
		filter_out_t predicted;
		logic calm;
		calm = samples_sent >= CALM_FROM && samples_sent < CALM_TO;
		if (!calm && $urandom_range(99) < 11) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat ($urandom_range(30)) @(negedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= z;
		do @(posedge clk); while (!sample_ready);
		predicted = kalman_update(z);
		expected_words.push_back(typed ? typed_out : predicted);
		samples_sent++;
	endtask

	function automatic void check_word();
		filter_out_t want;
		results_seen++;
		if (expected_words.size() == 0) begin
			note_mismatch("unexpected word", '0, estimate);
			return;
		end
		want = expected_words.pop_front();
		if (estimate !== want.estimate) note_mismatch("estimate", want.estimate, estimate);
		if (gain !== want.gain) note_mismatch("gain", want.gain, gain);
	endfunction

	// Result side: random stalls, one long hold, one stall-free stretch
	initial begin : result_side
		int hold_left;
		logic calm;
		hold_left = 0;
		forever begin
			@(negedge clk);
			calm = results_seen >= CALM_FROM && results_seen < CALM_TO;
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= calm || $urandom_range(99) >= 11;
			end
			@(posedge clk);
			if (result_valid && result_ready) begin
				check_word();
				if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("scalar_kalman_filter_core: mismatch");
		$finish;
	end

	initial begin : stimulus
		filter_out_t typed_out;
		int level;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				write_register(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				typed_out.estimate = directed_rows[i].estimate;
				typed_out.gain = directed_rows[i].gain;
				send_sample(directed_rows[i].sample, directed_rows[i].typed, typed_out);
			end
		end

		// Random phases, each with fresh noise settings and covariance
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_register(REG_PROCESS_NOISE, random_register_value());
			write_register(REG_MEASURE_NOISE, random_register_value());
			write_register(REG_INIT_COV, random_register_value());
			level = 0;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (n % 30 == 0) level = int'($urandom_range(65535)) - 32768;
				send_sample(random_sample(level), 1'b0, '0);
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("scalar_kalman_filter_core: match");
		end else begin
			$display("scalar_kalman_filter_core: mismatch");
		end
		$finish;
	end

endmodule
